// ===== src/sha512_pkg.sv =====
// SHA-512 package: round constants, initial hash values, helper functions and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
package sha512_pkg;

    localparam int unsigned ROUNDS = 80;
    localparam int unsigned BLOCK_BYTES = 128;
    localparam int unsigned LEN_POS = 112;

    typedef logic [63:0] word_t;

    function automatic word_t round_k(input logic [6:0] r);
        word_t k;
        begin
            case (r)
                7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
                7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
                7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
                7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
                7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
                7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
                7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
                7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
                7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
                7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
                7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
                7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
                7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
                7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
                7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
                7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
                7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
                7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
                7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
                7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
                7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
                7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
                7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
                7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
                7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
                7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
                7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
                7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
                7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
                7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
                7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
                7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
                7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
                7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
                7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
                7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
                7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
                7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
                7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
                7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
                default: k = 64'h0;
            endcase
            return k;
        end
    endfunction

    function automatic word_t init_hash(input logic [2:0] i);
        word_t h;
        begin
            case (i)
                3'd0: h = 64'h6a09e667f3bcc908;
                3'd1: h = 64'hbb67ae8584caa73b;
                3'd2: h = 64'h3c6ef372fe94f82b;
                3'd3: h = 64'ha54ff53a5f1d36f1;
                3'd4: h = 64'h510e527fade682d1;
                3'd5: h = 64'h9b05688c2b3e6c1f;
                3'd6: h = 64'h1f83d9abfb41bd6b;
                default: h = 64'h5be0cd19137e2179;
            endcase
            return h;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       write_byte;   // store byte_val at the fill position
        logic [7:0] byte_val;
        logic       count_byte;   // add 8 to the bit count
        logic       start_comp;   // load schedule and working vars
        logic       round_en;     // run one round
        logic       finish_comp;  // add working vars into hash words
        logic       snap_len;     // latch the bit count for padding
        logic       restart;      // back to initial hash, zero count/fill
    } sha_cmd_t;

    // Status from the datapath.
    typedef struct packed {
        logic [6:0]  fill;
        logic [6:0]  round;
        logic [127:0] len;
    } sha_stat_t;

endpackage

// ===== src/sha512_datapath.sv =====
// SHA-512 datapath: block buffer, bit count, message schedule and round logic.
// Depends on sha512_pkg.
module sha512_datapath import sha512_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sha_cmd_t  cmd,
    input  logic [2:0] rd_index,
    output word_t     hash_word,
    output sha_stat_t stat
);

    // The 128-byte block is held as sixteen big-endian words; byte n of the
    // block sits in word n/8, most significant byte first.
    word_t        buf_reg [16];
    logic [6:0]   fill_reg;
    logic [127:0] count_reg;
    logic [127:0] len_reg;
    logic [6:0]   round_reg;
    word_t        hash_reg [8];
    word_t        v_reg [8];
    word_t        w_reg [16];

    word_t w_cur, s0, s1, t1, t2, w_new;
    word_t blk_w [16];

    // The schedule load happens in the cycle that writes the last byte, so
    // that byte is merged in on its way to the schedule.
    always_comb begin
        for (int j = 0; j < 16; j++) begin
            blk_w[j] = buf_reg[j];
        end
        if (cmd.write_byte) begin
            blk_w[fill_reg[6:3]][{~fill_reg[2:0], 3'b000} +: 8] = cmd.byte_val;
        end
    end

    // The window is kept as a shift line: w_reg[0] is W[r].
    always_comb begin
        s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round_reg) + w_cur;
        t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            buf_reg[fill_reg[6:3]][{~fill_reg[2:0], 3'b000} +: 8] <= cmd.byte_val;
        end
        if (cmd.snap_len) begin
            len_reg <= count_reg;
        end
        if (cmd.start_comp) begin
            for (int j = 0; j < 16; j++) w_reg[j] <= blk_w[j];
            for (int j = 0; j < 8; j++) v_reg[j] <= hash_reg[j];
        end else if (cmd.round_en) begin
            for (int j = 0; j < 15; j++) w_reg[j] <= w_reg[j+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            for (int j = 0; j < 8; j++) hash_reg[j] <= init_hash(3'(j));
        end else begin
            if (cmd.write_byte) fill_reg <= fill_reg + 7'd1;
            if (cmd.count_byte) count_reg <= count_reg + 128'd8;
            if (cmd.start_comp) round_reg <= '0;
            else if (cmd.round_en) round_reg <= round_reg + 7'd1;
            if (cmd.finish_comp) begin
                for (int j = 0; j < 8; j++) hash_reg[j] <= hash_reg[j] + v_reg[j];
            end
        end
    end

    assign hash_word  = hash_reg[rd_index];
    assign stat.fill  = fill_reg;
    assign stat.round = round_reg;
    assign stat.len   = len_reg;

endmodule

// ===== src/sha512_ctrl.sv =====
// SHA-512 controller: sequences byte intake, padding, compression and digest
// output. Depends on sha512_pkg.
module sha512_ctrl import sha512_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_has_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_word_index,
    output logic       m_last_word,
    output logic [2:0] rd_index,
    output sha_cmd_t   cmd,
    input  sha_stat_t  stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       pad_reg, pad_next;      // padding in progress
    logic       first_reg, first_next;  // 0x80 byte not yet written
    logic       skip_reg, skip_next;    // length goes into the next block
    logic [2:0] idx_reg, idx_next;
    logic [7:0] pad_byte;
    logic [3:0] len_sel;

    always_comb begin
        len_sel = 4'(stat.fill - 7'(LEN_POS));
        pad_byte = 8'h00;
        if (first_reg) pad_byte = 8'h80;
        else if (!skip_reg && stat.fill >= 7'(LEN_POS)) begin
            pad_byte = stat.len[8'(127 - 8*len_sel) -: 8];
        end
    end

    always_comb begin
        state_next = state_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        skip_next  = skip_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.byte_val = s_data_byte;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.write_byte = s_has_byte;
                    cmd.count_byte = s_has_byte;
                    if (s_has_byte && stat.fill == 7'd127) begin
                        cmd.start_comp = 1'b1;
                        state_next = ST_COMP;
                        pad_next = s_is_last;
                        first_next = s_is_last;
                    end else if (s_is_last) begin
                        state_next = ST_PAD;
                        pad_next = 1'b1;
                        first_next = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                cmd.write_byte = 1'b1;
                cmd.byte_val = pad_byte;
                cmd.snap_len = first_reg;
                first_next = 1'b0;
                // A 0x80 at or past the length field leaves no room for the length.
                if (first_reg && stat.fill >= 7'(LEN_POS)) skip_next = 1'b1;
                if (stat.fill == 7'd127) begin
                    cmd.start_comp = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP: begin
                if (pad_reg && first_reg) cmd.snap_len = 1'b1;
                cmd.round_en = 1'b1;
                if (stat.round == 7'(ROUNDS - 1)) state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish_comp = 1'b1;
                if (!pad_reg) state_next = ST_IDLE;
                else if (first_reg || skip_reg) begin
                    state_next = ST_PAD;
                    skip_next = 1'b0;
                end else begin
                    // The block that held the length is done.
                    state_next = ST_OUT;
                    idx_next = '0;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.restart = 1'b1;
                        pad_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // In ST_FIN after a padded block, fill is 0. Another padding block follows
    // when the 0x80 is still to be written, or when it landed in the length
    // field's bytes so that the block carried only zeros after it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            skip_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            skip_reg  <= skip_next;
            idx_reg   <= idx_next;
        end
    end

    assign rd_index     = idx_reg;
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'd7);

    a_out_only_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == ST_OUT) else $error("result shown outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input taken while digest pending");
    a_comp_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_comp |=> state_reg == ST_COMP && stat.round == 7'd0)
        else $error("compression did not start cleanly");

endmodule

// ===== src/sha512_stream_hasher.sv =====
// SHA-512 stream hasher: one byte item per cycle while idle; the item that fills a
// block is followed by a busy compression (80 rounds plus the hash update).
// The first digest word follows the end mark once the padding (up to 144 bytes,
// one per cycle) and one or two compressions are done.
// The eight result items then follow, one per cycle while they are accepted.
// Reset (aresetn, synchronous, active low) loads the initial hash values.
module sha512_stream_hasher import sha512_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    // The controller drives the datapath through a command struct; the
    // datapath reports fill level, round count and the latched length. The
    // padding runs byte by byte through the same buffer, so the 0x80, zero
    // fill and big-endian 128-bit length are written exactly as a message
    // would be, and the compression fires whenever the buffer wraps.
    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0] rd_index;

    sha512_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_has_byte   (s_has_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .rd_index     (rd_index),
        .cmd          (cmd),
        .stat         (stat)
    );

    sha512_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_index  (rd_index),
        .hash_word (m_digest_word),
        .stat      (stat)
    );

endmodule
